/* rtl/kat_pkg.sv */
// ----------------------------------------------------------------------------
// kat_pkg
// Shared types and constants for the keyed arm table: operation codes,
// controller states and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package kat_pkg;

  localparam int DEFAULT_SLOTS = 16;

  localparam int OP_W    = 2;
  localparam int PID_W   = 32;
  localparam int STIME_W = 64;
  localparam int KIND_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ARM    = 2'd1,
    OP_DISARM = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_APPLY = 2'd2
  } state_t;

  typedef struct packed {
    logic load;     // capture the incoming key
    logic compare;  // register per-slot match vectors
    logic apply;    // update table, load result register
  } cmd_t;

endpackage

/* rtl/keyed_arm_table_core.sv */
// ----------------------------------------------------------------------------
// keyed_arm_table_core
// Set of armed keys (process id, start time, event kind): lookup, arm into
// the lowest free slot with drop flag, and disarm by process id/start time.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_ready  op, proc_id, start_time, event_kind
//  output   out_valid / out_ready is_armed, arm_dropped
//
//  a transaction steps through capture, per-slot compare and apply/result;
//  a new transaction is taken only after the previous one's apply step,
//  following the capture -> compare -> apply sequence in the controller
//  reset clears every slot valid bit at once; no clearing pass
//  apply waits while an earlier result is held and not taken; input is
//  taken again as soon as apply is done, even with a result pending
// ----------------------------------------------------------------------------
module keyed_arm_table_core #(
  parameter int TABLE_SLOTS = kat_pkg::DEFAULT_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [kat_pkg::OP_W-1:0]           op,
  input  logic [kat_pkg::PID_W-1:0]          proc_id,
  input  logic signed [kat_pkg::STIME_W-1:0] start_time,
  input  logic [kat_pkg::KIND_W-1:0]         event_kind,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_armed,
  output logic                               arm_dropped
);
  import kat_pkg::*;

  cmd_t cmd;

  kat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  kat_datapath #(
    .SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .proc_id     (proc_id),
    .start_time  (start_time),
    .event_kind  (event_kind),
    .is_armed    (is_armed),
    .arm_dropped (arm_dropped)
  );

`ifndef SYNTHESIS
  // a result never reports both a hit and a drop
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_armed && arm_dropped))
    else $error("is_armed and arm_dropped both set");

  // after taking a transaction the block is busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while transaction in progress");

  // a new result only appears right after the apply step
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.apply))
    else $error("result raised without a transaction in progress");
`endif

endmodule

/* rtl/kat_ctrl.sv */
// ----------------------------------------------------------------------------
// kat_ctrl
// Sequencer for the keyed arm table: accepts one transaction, steps it
// through compare and apply, and owns the result valid flag.
// ----------------------------------------------------------------------------
module kat_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output kat_pkg::cmd_t cmd
);
  import kat_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.compare = 1'b1;
        state_next  = ST_APPLY;
      end
      ST_APPLY: begin
        // hold until the result register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.apply) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* rtl/kat_datapath.sv */
// ----------------------------------------------------------------------------
// kat_datapath
// Key register, slot storage, per-slot compare cells, lowest-free pick and
// the result register.
// ----------------------------------------------------------------------------
module kat_datapath #(
  parameter int SLOTS = kat_pkg::DEFAULT_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kat_pkg::cmd_t                     cmd,
  input  logic [kat_pkg::OP_W-1:0]          op,
  input  logic [kat_pkg::PID_W-1:0]         proc_id,
  input  logic signed [kat_pkg::STIME_W-1:0] start_time,
  input  logic [kat_pkg::KIND_W-1:0]        event_kind,
  output logic                              is_armed,
  output logic                              arm_dropped
);
  import kat_pkg::*;

  // captured key
  logic [OP_W-1:0]    key_op;
  logic [PID_W-1:0]   key_pid;
  logic [STIME_W-1:0] key_st;
  logic [KIND_W-1:0]  key_kind;

  // slot storage
  logic [SLOTS-1:0]   slot_valid;
  logic [PID_W-1:0]   slot_pid  [SLOTS];
  logic [STIME_W-1:0] slot_st   [SLOTS];
  logic [KIND_W-1:0]  slot_kind [SLOTS];

  // registered per-slot compare results
  logic [SLOTS-1:0]   hit_vec;
  logic [SLOTS-1:0]   ident_vec;
  logic [SLOTS-1:0]   free_vec;

  logic               any_hit;
  logic               have_free;
  logic [SLOTS-1:0]   pick;
  logic               do_arm;
  logic               do_disarm;
  logic               res_armed;
  logic               res_dropped;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_op   <= op;
      key_pid  <= proc_id;
      key_st   <= $unsigned(start_time);
      key_kind <= event_kind;
    end
  end

  // one compare cell per slot
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < SLOTS; i++) begin
        ident_vec[i] <= slot_valid[i] && (slot_pid[i] == key_pid) && (slot_st[i] == key_st);
        hit_vec[i]   <= slot_valid[i] && (slot_pid[i] == key_pid) && (slot_st[i] == key_st)
                        && (slot_kind[i] == key_kind);
        free_vec[i]  <= !slot_valid[i];
      end
    end
  end

  assign any_hit   = |hit_vec;
  assign have_free = |free_vec;
  // isolate the lowest set bit: lowest-numbered free slot
  assign pick      = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});

  always_comb begin
    do_arm      = 1'b0;
    do_disarm   = 1'b0;
    res_armed   = 1'b0;
    res_dropped = 1'b0;
    case (op_t'(key_op))
      OP_LOOKUP: begin
        res_armed = any_hit;
      end
      OP_ARM: begin
        do_arm      = !any_hit && have_free;
        res_dropped = !any_hit && !have_free;
      end
      OP_DISARM: begin
        do_disarm = 1'b1;
      end
      default: begin
        do_arm = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.apply) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (do_arm && pick[i]) begin
          slot_valid[i] <= 1'b1;
        end else if (do_disarm && ident_vec[i]) begin
          slot_valid[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (do_arm && pick[i]) begin
          slot_pid[i]  <= key_pid;
          slot_st[i]   <= key_st;
          slot_kind[i] <= key_kind;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      is_armed    <= res_armed;
      arm_dropped <= res_dropped;
    end
  end

endmodule
